@@ hdl/word_dictionary_tokenizer_top_macros.svh @@
// Assertion macros for the word dictionary tokeniser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WORD_DICTIONARY_TOKENIZER_TOP_MACROS_SVH
`define WORD_DICTIONARY_TOKENIZER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define WTOK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// cond must never be true outside reset
`define WTOK_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WTOK_ASSERT(lbl, clk, rst, prop, msg)
`define WTOK_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ hdl/wtok_pkg.sv @@
// Shared constants and types for the word dictionary tokeniser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package wtok_pkg;

   localparam int DICT_DEPTH       = 1024;
   localparam int MAX_WORD_LETTERS = 7;
   localparam int LETTER_BITS      = 5;

   localparam int BYTE_W = 8;
   localparam int CODE_W = MAX_WORD_LETTERS * LETTER_BITS;
   localparam int LEN_W  = $clog2(MAX_WORD_LETTERS + 1);
   localparam int IDX_W  = $clog2(DICT_DEPTH);
   localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
   localparam int POS_W  = 14;

   localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'd32;
   localparam logic [BYTE_W-1:0] LETTER_BASE  = 8'd96;
   localparam logic [BYTE_W-1:0] LETTER_FIRST = 8'd97;
   localparam logic [BYTE_W-1:0] LETTER_LAST  = 8'd122;

   // current word as held by the assembler
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
      logic [POS_W-1:0]  position;
      logic              too_long;
   } word_info_type;

   // dictionary memory port controls
   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [CODE_W-1:0] wr_data;
   } mem_req_type;

endpackage

@@ hdl/wtok_word.sv @@
// Word assembler: packs letters into a base-32 code, tracks length, overflow
// and word ordinal. Depends on wtok_pkg.
`timescale 1ns / 1ps

module wtok_word (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [wtok_pkg::BYTE_W-1:0]  char_byte,
   input  logic                         word_done,
   output wtok_pkg::word_info_type      word
);

   logic [wtok_pkg::CODE_W-1:0]      code_ff, code_in;
   logic [wtok_pkg::LEN_W-1:0]       length_ff, length_in;
   logic [wtok_pkg::POS_W-1:0]       position_ff, position_in;
   logic                             too_long_ff, too_long_in;
   logic                             is_letter;
   logic [wtok_pkg::BYTE_W-1:0]      letter_diff;
   logic [wtok_pkg::LETTER_BITS-1:0] letter;

   always_comb begin
      is_letter   = char_byte inside {[wtok_pkg::LETTER_FIRST:wtok_pkg::LETTER_LAST]};
      letter_diff = char_byte - wtok_pkg::LETTER_BASE;
      letter      = letter_diff[wtok_pkg::LETTER_BITS-1:0];

      code_in     = code_ff;
      length_in   = length_ff;
      position_in = position_ff;
      too_long_in = too_long_ff;

      if (word_done) begin
         code_in     = '0;
         length_in   = '0;
         too_long_in = 1'b0;
         position_in = position_ff + wtok_pkg::POS_W'(1);
      end else if (accept && is_letter) begin
         if (length_ff < wtok_pkg::LEN_W'(wtok_pkg::MAX_WORD_LETTERS)) begin
            // top letter slot is always empty here, so the shift loses nothing
            code_in   = {code_ff[wtok_pkg::CODE_W-wtok_pkg::LETTER_BITS-1:0], letter};
            length_in = length_ff + wtok_pkg::LEN_W'(1);
         end else begin
            too_long_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff     <= '0;
         length_ff   <= '0;
         position_ff <= '0;
         too_long_ff <= 1'b0;
      end else begin
         code_ff     <= code_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         too_long_ff <= too_long_in;
      end
   end

   assign word.code     = code_ff;
   assign word.length   = length_ff;
   assign word.position = position_ff;
   assign word.too_long = too_long_ff;

endmodule

@@ hdl/wtok_dict_mem.sv @@
// Dictionary code store: one write port, one registered read port.
// Depends on wtok_pkg.
`timescale 1ns / 1ps

module wtok_dict_mem (
   input  logic                         clock,
   input  wtok_pkg::mem_req_type        mem_req,
   output logic [wtok_pkg::CODE_W-1:0]  rd_data
);

   logic [wtok_pkg::CODE_W-1:0] mem_ff [wtok_pkg::DICT_DEPTH];
   logic [wtok_pkg::CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/wtok_search.sv @@
// Search sequencer: linear scan of the dictionary with one shared comparator,
// insert on miss, and the result register. Depends on wtok_pkg and the macros.
`timescale 1ns / 1ps
`include "word_dictionary_tokenizer_top_macros.svh"

module wtok_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          space_go,
   input  wtok_pkg::word_info_type       word,
   input  logic [wtok_pkg::CODE_W-1:0]   rd_data,
   output wtok_pkg::mem_req_type         mem_req,
   output logic                          word_done,
   output logic                          idle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wtok_pkg::IDX_W-1:0]    rsp_word_index,
   output logic                          rsp_is_new,
   output logic [wtok_pkg::CODE_W-1:0]   rsp_word_code,
   output logic [wtok_pkg::LEN_W-1:0]    rsp_word_length,
   output logic [wtok_pkg::POS_W-1:0]    rsp_word_position,
   output logic                          rsp_dict_full,
   output logic                          rsp_too_long
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [wtok_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [wtok_pkg::CNT_W-1:0]   issue_ff, issue_in;
   logic [wtok_pkg::IDX_W-1:0]   tag_ff, tag_in;
   logic                         tag_valid_ff, tag_valid_in;
   logic [wtok_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                         new_ff, new_in;
   logic                         full_ff, full_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [wtok_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                         rsp_new_ff, rsp_new_in;
   logic [wtok_pkg::CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [wtok_pkg::LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic [wtok_pkg::POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic                         rsp_full_ff, rsp_full_in;
   logic                         rsp_too_long_ff, rsp_too_long_in;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      issue_in        = issue_ff;
      tag_in          = tag_ff;
      tag_valid_in    = 1'b0;
      idx_in          = idx_ff;
      new_in          = new_ff;
      full_in         = full_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_new_in      = rsp_new_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_position_in = rsp_position_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_too_long_in = rsp_too_long_ff;
      word_done       = 1'b0;
      mem_req         = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (space_go) begin
               issue_in = '0;
               // empty dictionary: straight to insert
               if (count_ff == '0) begin
                  state_in = S_RESOLVE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // compare the entry read last cycle while the next one is read
            if (tag_valid_ff && (rd_data == word.code)) begin
               idx_in   = tag_ff;
               new_in   = 1'b0;
               full_in  = 1'b0;
               state_in = S_EMIT;
            end else if (tag_valid_ff &&
                         (wtok_pkg::CNT_W'(tag_ff) + wtok_pkg::CNT_W'(1) == count_ff)) begin
               state_in = S_RESOLVE;
            end else if (issue_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = issue_ff[wtok_pkg::IDX_W-1:0];
               tag_in          = issue_ff[wtok_pkg::IDX_W-1:0];
               tag_valid_in    = 1'b1;
               issue_in        = issue_ff + wtok_pkg::CNT_W'(1);
            end
         end
         S_RESOLVE: begin
            if (count_ff < wtok_pkg::CNT_W'(wtok_pkg::DICT_DEPTH)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = count_ff[wtok_pkg::IDX_W-1:0];
               mem_req.wr_data = word.code;
               idx_in          = count_ff[wtok_pkg::IDX_W-1:0];
               new_in          = 1'b1;
               full_in         = 1'b0;
               count_in        = count_ff + wtok_pkg::CNT_W'(1);
            end else begin
               // dictionary full: word not stored, index reads as zero
               idx_in  = '0;
               new_in  = 1'b0;
               full_in = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_index_in    = idx_ff;
               rsp_new_in      = new_ff;
               rsp_full_in     = full_ff;
               rsp_code_in     = word.code;
               rsp_length_in   = word.length;
               rsp_position_in = word.position;
               rsp_too_long_in = word.too_long;
               word_done       = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tag_valid_ff <= tag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff        <= issue_in;
      tag_ff          <= tag_in;
      idx_ff          <= idx_in;
      new_ff          <= new_in;
      full_ff         <= full_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_new_ff      <= rsp_new_in;
      rsp_code_ff     <= rsp_code_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_position_ff <= rsp_position_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_too_long_ff <= rsp_too_long_in;
   end

   assign idle              = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word_index    = rsp_index_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_word_code     = rsp_code_ff;
   assign rsp_word_length   = rsp_length_ff;
   assign rsp_word_position = rsp_position_ff;
   assign rsp_dict_full     = rsp_full_ff;
   assign rsp_too_long      = rsp_too_long_ff;

   `WTOK_ASSERT(a_insert_bumps_count, clock, reset, mem_req.wr_en |=> (count_ff == $past(count_ff) + wtok_pkg::CNT_W'(1)), "insert did not advance entry count")
   `WTOK_ASSERT(a_tag_below_count, clock, reset, tag_valid_ff |-> (wtok_pkg::CNT_W'(tag_ff) < count_ff), "scan compared an entry beyond the count")
   `WTOK_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT), "response raised outside emit")
   `WTOK_ASSERT_NEVER(a_new_and_full, clock, reset, rsp_valid_ff && rsp_new_ff && rsp_full_ff, "response flagged both new and full")

endmodule

@@ hdl/word_dictionary_tokenizer_top.sv @@
// Top level of the word dictionary tokeniser.
// Depends on wtok_pkg, wtok_word, wtok_dict_mem and wtok_search.
`timescale 1ns / 1ps

// Takes text one byte per request. Lowercase letters build the current word as
// 5-bit codes (a=1), first letter most significant; letters past the seventh
// are dropped and flagged too_long. A space ends the word (an empty word
// counts too) and gives one response: the word's dictionary index, whether it
// was just added, its code, length and ordinal. Other bytes are ignored.
// A letter or ignored byte is taken without a stall. A space raises req_stall
// until its response is loaded: an empty dictionary goes straight to the insert,
// and otherwise the dictionary is walked one entry per cycle through a single
// registered-read memory port and one 35-bit comparator; a miss then inserts
// the word, and a last step loads the response.
// If a previous response is still stalled, the block waits on it. When the
// dictionary holds 1024 entries a new word gets index 0 and dict_full.

module word_dictionary_tokenizer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wtok_pkg::BYTE_W-1:0]   req_char_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wtok_pkg::IDX_W-1:0]    rsp_word_index,
   output logic                          rsp_is_new,
   output logic [wtok_pkg::CODE_W-1:0]   rsp_word_code,
   output logic [wtok_pkg::LEN_W-1:0]    rsp_word_length,
   output logic [wtok_pkg::POS_W-1:0]    rsp_word_position,
   output logic                          rsp_dict_full,
   output logic                          rsp_too_long
);

   logic                          accept;
   logic                          space_go;
   logic                          word_done;
   logic                          idle;
   wtok_pkg::word_info_type       word;
   wtok_pkg::mem_req_type         mem_req;
   logic [wtok_pkg::CODE_W-1:0]   rd_data;

   // requests are only taken while no search is running
   assign req_stall = !idle;
   assign accept    = req_valid && !req_stall;
   assign space_go  = accept && (req_char_byte == wtok_pkg::SPACE_BYTE);

   wtok_word u_word (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_char_byte),
      .word_done (word_done),
      .word      (word)
   );

   wtok_dict_mem u_dict_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   wtok_search u_search (
      .clock             (clock),
      .reset             (reset),
      .space_go          (space_go),
      .word              (word),
      .rd_data           (rd_data),
      .mem_req           (mem_req),
      .word_done         (word_done),
      .idle              (idle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word_index    (rsp_word_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_word_code     (rsp_word_code),
      .rsp_word_length   (rsp_word_length),
      .rsp_word_position (rsp_word_position),
      .rsp_dict_full     (rsp_dict_full),
      .rsp_too_long      (rsp_too_long)
   );

endmodule

@@ tb/word_dictionary_tokenizer_checker.sv @@
// Scoreboard for the word dictionary tokeniser: models every accepted request and checks
// every accepted response against it. Depends on wtok_pkg for widths and byte codes.
`timescale 1ns / 1ps

module word_dictionary_tokenizer_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [wtok_pkg::BYTE_W-1:0] req_char_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [wtok_pkg::IDX_W-1:0]  rsp_word_index,
   input  logic                        rsp_is_new,
   input  logic [wtok_pkg::CODE_W-1:0] rsp_word_code,
   input  logic [wtok_pkg::LEN_W-1:0]  rsp_word_length,
   input  logic [wtok_pkg::POS_W-1:0]  rsp_word_position,
   input  logic                        rsp_dict_full,
   input  logic                        rsp_too_long,
   output int                          error_count,
   output int                          words_outstanding,
   output int                          entries_held,
   output int                          words_checked,
   output int                          full_responses
);

   typedef struct packed {
      logic [wtok_pkg::IDX_W-1:0]  index;
      logic                        is_new;
      logic [wtok_pkg::CODE_W-1:0] code;
      logic [wtok_pkg::LEN_W-1:0]  length;
      logic [wtok_pkg::POS_W-1:0]  position;
      logic                        full;
      logic                        too_long;
   } word_result_type;

   // model of the dictionary and the word being assembled
   logic [wtok_pkg::CODE_W-1:0] dict_codes [wtok_pkg::DICT_DEPTH];
   int                          dict_count;
   logic [wtok_pkg::CODE_W-1:0] cur_code;
   logic [wtok_pkg::LEN_W-1:0]  cur_len;
   logic                        cur_long;
   logic [wtok_pkg::POS_W-1:0]  word_ordinal;
   word_result_type             words_due [$];

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic tokenise_byte(input logic [wtok_pkg::BYTE_W-1:0] b);
      word_result_type             res;
      logic [wtok_pkg::BYTE_W-1:0] ltr;
      int                          slot;
      int                          j;
      if (b >= wtok_pkg::LETTER_FIRST && b <= wtok_pkg::LETTER_LAST) begin
         if (cur_len < wtok_pkg::LEN_W'(wtok_pkg::MAX_WORD_LETTERS)) begin
            ltr      = b - wtok_pkg::LETTER_BASE;
            cur_code = {cur_code[wtok_pkg::CODE_W-wtok_pkg::LETTER_BITS-1:0],
                        ltr[wtok_pkg::LETTER_BITS-1:0]};
            cur_len  = cur_len + 1'b1;
         end else begin
            cur_long = 1'b1;
         end
      end else if (b == wtok_pkg::SPACE_BYTE) begin
         // linear search by code; equal codes imply equal lengths
         slot = -1;
         for (j = 0; j < dict_count && slot < 0; j++)
            if (dict_codes[j] == cur_code) slot = j;
         res = '0;
         if (slot >= 0) begin
            res.index = slot[wtok_pkg::IDX_W-1:0];
         end else if (dict_count < wtok_pkg::DICT_DEPTH) begin
            dict_codes[dict_count] = cur_code;
            res.index  = dict_count[wtok_pkg::IDX_W-1:0];
            res.is_new = 1'b1;
            dict_count++;
         end else begin
            res.full = 1'b1;
         end
         res.code     = cur_code;
         res.length   = cur_len;
         res.position = word_ordinal;
         res.too_long = cur_long;
         words_due.push_back(res);
         word_ordinal = word_ordinal + 1'b1;
         cur_code     = '0;
         cur_len      = '0;
         cur_long     = 1'b0;
      end
   endtask

   always @(posedge clock) begin : monitor
      word_result_type want;
      if (reset) begin
         dict_count     = 0;
         cur_code       = '0;
         cur_len        = '0;
         cur_long       = 1'b0;
         word_ordinal   = '0;
         error_count    = 0;
         words_checked  = 0;
         full_responses = 0;
         words_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               $display("%0t: response with no word pending, expected none, got index 0x%0h code 0x%0h",
                        $time, rsp_word_index, rsp_word_code);
               error_count++;
            end else begin
               want = words_due.pop_front();
               check_field("word_index",    64'(want.index),    64'(rsp_word_index));
               check_field("is_new",        64'(want.is_new),   64'(rsp_is_new));
               check_field("word_code",     64'(want.code),     64'(rsp_word_code));
               check_field("word_length",   64'(want.length),   64'(rsp_word_length));
               check_field("word_position", 64'(want.position), 64'(rsp_word_position));
               check_field("dict_full",     64'(want.full),     64'(rsp_dict_full));
               check_field("too_long",      64'(want.too_long), 64'(rsp_too_long));
               words_checked++;
               if (want.full) full_responses++;
            end
         end
         if (req_valid && !req_stall) tokenise_byte(req_char_byte);
      end
      words_outstanding = words_due.size();
      entries_held      = dict_count;
   end

endmodule

@@ tb/tb.sv @@
// Testbench top for the word dictionary tokeniser: clock, reset, text stimulus and verdict.
// Depends on wtok_pkg, word_dictionary_tokenizer_top and word_dictionary_tokenizer_checker.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_REQUESTS = 490;  // opening plus random text, requests
   localparam int TAIL_WORDS      = 15;   // closing words sent without idling
   localparam int MAX_TEXT        = 12;   // longest word sent, letters
   // Worst case per request: a space scanning the whole dictionary plus a sender
   // gap and a response stall; some 600 requests in all, so the limit leaves ample
   // margin.
   localparam int CYCLE_LIMIT     = 3_000_000;

   // opening requests, first byte in the top slot:
   // two empty words, "az" from edge letters amid ignored bytes at the edges of the letter
   // and space codes, a nine-letter word of 'z' that overflows, then "az" again as a hit
   localparam logic [8*25-1:0] OPENING = {
      8'd32, 8'd32, 8'd0, 8'd97, 8'd255, 8'd122, 8'd96, 8'd123, 8'd31, 8'd33, 8'd65,
      8'd32, {9{8'd122}}, 8'd32, 8'd97, 8'd122, 8'd32};

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [wtok_pkg::BYTE_W-1:0]   req_char_byte;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [wtok_pkg::IDX_W-1:0]    rsp_word_index;
   logic                          rsp_is_new;
   logic [wtok_pkg::CODE_W-1:0]   rsp_word_code;
   logic [wtok_pkg::LEN_W-1:0]    rsp_word_length;
   logic [wtok_pkg::POS_W-1:0]    rsp_word_position;
   logic                          rsp_dict_full;
   logic                          rsp_too_long;

   int error_count;
   int words_outstanding;
   int entries_held;
   int words_checked;
   int full_responses;

   bit idle_on;          // random gaps on both channels while set
   int requests_sent;    // every accepted request
   int text_items;       // accepted letters and spaces only

   // words sent so far, reused later as dictionary hits
   logic [8*MAX_TEXT-1:0] seen_text [$];
   int                    seen_len  [$];

   word_dictionary_tokenizer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word_index    (rsp_word_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_word_code     (rsp_word_code),
      .rsp_word_length   (rsp_word_length),
      .rsp_word_position (rsp_word_position),
      .rsp_dict_full     (rsp_dict_full),
      .rsp_too_long      (rsp_too_long)
   );

   word_dictionary_tokenizer_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_byte     (req_char_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_word_index    (rsp_word_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_word_code     (rsp_word_code),
      .rsp_word_length   (rsp_word_length),
      .rsp_word_position (rsp_word_position),
      .rsp_dict_full     (rsp_dict_full),
      .rsp_too_long      (rsp_too_long),
      .error_count       (error_count),
      .words_outstanding (words_outstanding),
      .entries_held      (entries_held),
      .words_checked     (words_checked),
      .full_responses    (full_responses)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d words still pending", CYCLE_LIMIT,
               words_outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stall bursts while idling is on
   initial begin : rsp_idle
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Entered on a falling edge, returns on the falling edge after acceptance with
   // valid still high; the caller either drives the next request at once or
   // lowers valid itself.
   task automatic put_byte(input logic [wtok_pkg::BYTE_W-1:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if (b == wtok_pkg::SPACE_BYTE ||
          (b >= wtok_pkg::LETTER_FIRST && b <= wtok_pkg::LETTER_LAST)) text_items++;
   endtask

   // any byte that is neither a letter nor a space
   function automatic logic [wtok_pkg::BYTE_W-1:0] noise_byte();
      logic [wtok_pkg::BYTE_W-1:0] r;
      r = wtok_pkg::BYTE_W'($urandom_range(0, 255));
      if (r == wtok_pkg::SPACE_BYTE ||
          (r >= wtok_pkg::LETTER_FIRST && r <= wtok_pkg::LETTER_LAST)) r = r ^ 8'h80;
      return r;
   endfunction

   function automatic logic [8*MAX_TEXT-1:0] random_word(input int len);
      logic [8*MAX_TEXT-1:0] txt;
      int                    i;
      txt = '0;
      for (i = 0; i < len; i++)
         txt[8*i +: 8] = wtok_pkg::LETTER_FIRST + 8'($urandom_range(0, 25));
      return txt;
   endfunction

   // letters of one word, ignored bytes sprinkled in when noisy, closing space
   task automatic send_word(input logic [8*MAX_TEXT-1:0] txt, input int len, input bit noisy);
      int i;
      for (i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 5) == 0) put_byte(noise_byte());
         put_byte(txt[8*i +: 8]);
      end
      if (noisy && $urandom_range(0, 3) == 0) put_byte(noise_byte());
      put_byte(wtok_pkg::SPACE_BYTE);
      seen_text.push_back(txt);
      seen_len.push_back(len);
   endtask

   initial begin : stimulus
      int i;
      int len;
      int r;
      int pick;
      bit paused;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = '0;
      idle_on       = 1'b0;
      requests_sent = 0;
      text_items    = 0;
      paused        = 1'b0;
      repeat (6) @(negedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // directed opening
      for (i = 24; i >= 0; i--) put_byte(OPENING[8*i +: 8]);

      // Random text: mostly fresh words of random letters, a quarter repeats of
      // earlier words, some empty and overlong words, and stray bytes of any value.
      while (requests_sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 11) == 0) idle_on = !idle_on;
         // halfway through, hold off until every pending word has come back
         if (!paused && requests_sent >= RANDOM_REQUESTS / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(negedge clock);
            while (words_outstanding != 0) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 25 && seen_len.size() > 0) begin
            pick = $urandom_range(0, seen_len.size() - 1);
            send_word(seen_text[pick], seen_len[pick], r < 8);
         end else if (r < 32) begin
            put_byte(wtok_pkg::BYTE_W'($urandom_range(0, 255)));
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0)     len = 0;
            else if (r < 3) len = $urandom_range(wtok_pkg::MAX_WORD_LETTERS + 1, MAX_TEXT);
            else            len = $urandom_range(1, wtok_pkg::MAX_WORD_LETTERS);
            send_word(random_word(len), len, $urandom_range(0, 3) == 0);
         end
      end

      // Closing words with no idling: hits on held words, the empty word and
      // fresh words, back to back.
      idle_on = 1'b0;
      for (i = 0; i < TAIL_WORDS; i++) begin
         r = $urandom_range(0, 3);
         if (r == 0 && seen_len.size() > 0) begin
            pick = $urandom_range(0, seen_len.size() - 1);
            send_word(seen_text[pick], seen_len[pick], 1'b0);
         end else if (r == 1 && $urandom_range(0, 1) == 0) begin
            send_word('0, 0, 1'b0);
         end else begin
            len = $urandom_range(1, MAX_TEXT);
            send_word(random_word(len), len, 1'b0);
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (words_outstanding != 0) @(negedge clock);
      // a stray response could still be on its way after a long search
      repeat (wtok_pkg::DICT_DEPTH + 8) @(negedge clock);

      $display("Run covered %0d requests (%0d letters and spaces), %0d words checked,",
               requests_sent, text_items, words_checked);
      $display("dictionary held %0d entries at the end, %0d words flagged full",
               entries_held, full_responses);
      if (error_count == 0 && words_outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
